@@ rtl/core/fcs_pkg.sv @@
// fcs_pkg: shared constants for the allocation-table chain walker
// command and status codes, table end codes, field widths
// no dependencies
package fcs_pkg;

  localparam int unsigned MAX_CHAIN_DEF = 256;

  // packed stream widths
  localparam int unsigned IN_W  = 64;
  localparam int unsigned OUT_W = 64;

  // chain length counter, holds 0..256
  localparam int unsigned LEN_W = 9;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_OPEN  = 2'd1;
  localparam logic [1:0] CMD_SEEK  = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_CHAIN = 2'd2;

  localparam logic [7:0] LAST_BLOCK_CODE = 8'hbf;
  localparam logic [7:0] END_CODE_LOW    = 8'hc1;
  localparam logic [7:0] END_CODE_HIGH   = 8'hc8;

  localparam logic [7:0] SECTOR_BYTES    = 8'd255;
  localparam logic [4:0] ODD_SECTOR_BASE = 5'd8;

endpackage

@@ rtl/core/fat_chain_seek.sv @@
// fat_chain_seek: allocation table, chain walk on open, offset to sector on seek
// holds the allocation table and the chain list in two synchronous memories
// depends on fcs_pkg
//
// channel   dir  width  fields (lowest bit first)
// s_axis    in   64     command, table_index, table_value, first_block,
//                       last_bytes, file_offset
// m_axis    out  64     status, block_number, track_number, sector_number,
//                       byte_in_sector, size_of_file, chain_length
//
// table write and unused command: accepted in IDLE, then PLAIN sends the result
// seek: quotient estimate, correction, chain list read, sector math
// open: each chain step passes WALK and WAIT (alloc table read), at most MAX_CHAIN steps, then OFIN
// reset clears control and the file registers; memory contents are undefined
// a held result stalls the block in its final state; a new item is taken only when idle
module fat_chain_seek #(
  parameter int unsigned MAX_CHAIN = fcs_pkg::MAX_CHAIN_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // command[1:0] table_index[9:2] table_value[17:10] first_block[25:18]
  // last_bytes[41:26] file_offset[61:42], zero above
  input  logic [fcs_pkg::IN_W-1:0] s_axis_tdata_i,
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  // status[1:0] block_number[9:2] track_number[16:10] sector_number[21:17]
  // byte_in_sector[29:22] size_of_file[49:30] chain_length[58:50], zero above
  output logic [fcs_pkg::OUT_W-1:0] m_axis_tdata_o
);

  localparam int unsigned CL_AW = (MAX_CHAIN > 1) ? $clog2(MAX_CHAIN) : 1;
  localparam int unsigned LEN_W = fcs_pkg::LEN_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PLAIN  = 3'd1;
  localparam logic [2:0] ST_WALK   = 3'd2;
  localparam logic [2:0] ST_WAIT   = 3'd3;
  localparam logic [2:0] ST_OFIN   = 3'd4;
  localparam logic [2:0] ST_SK_IDX = 3'd5;
  localparam logic [2:0] ST_SK_CHK = 3'd6;
  localparam logic [2:0] ST_SK_OUT = 3'd7;

  // input fields
  logic [1:0]  in_cmd;
  logic [7:0]  in_tidx;
  logic [7:0]  in_tval;
  logic [7:0]  in_first;
  logic [15:0] in_lbytes;
  logic [19:0] in_offset;

  assign in_cmd    = s_axis_tdata_i[1:0];
  assign in_tidx   = s_axis_tdata_i[9:2];
  assign in_tval   = s_axis_tdata_i[17:10];
  assign in_first  = s_axis_tdata_i[25:18];
  assign in_lbytes = s_axis_tdata_i[41:26];
  assign in_offset = s_axis_tdata_i[61:42];

  logic [2:0]       state_q, state_d;
  logic [LEN_W-1:0] count_q, count_d;
  logic [3:0]       lsc_q, lsc_d;
  logic [19:0]      size_q, size_d;
  logic [LEN_W-1:0] steps_q, steps_d;
  logic [7:0]       next_q, next_d;
  logic [15:0]      lbytes_q, lbytes_d;
  logic [19:0]      offset_q, offset_d;
  logic [9:0]       idx_q, idx_d;
  logic [7:0]       rmod_q, rmod_d;
  logic             bad_q, bad_d;

  logic             out_valid_q, out_valid_d;
  logic [1:0]       o_status_q, o_status_d;
  logic [7:0]       o_block_q, o_block_d;
  logic [6:0]       o_track_q, o_track_d;
  logic [4:0]       o_sector_q, o_sector_d;
  logic [7:0]       o_byte_q, o_byte_d;
  logic [19:0]      o_size_q, o_size_d;
  logic [LEN_W-1:0] o_len_q, o_len_d;

  logic in_xfer;
  logic out_free;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  // memory ports
  logic             alloc_we;
  logic             alloc_re;
  logic [7:0]       alloc_raddr;
  logic [7:0]       alloc_rdata_q;
  logic             chain_we;
  logic             chain_re;
  logic [CL_AW-1:0] chain_waddr;
  logic [CL_AW-1:0] chain_raddr;
  logic [7:0]       chain_rdata_q;

  logic [7:0] alloc_mem [256];
  logic [7:0] chain_mem [MAX_CHAIN];

  // table writes and open reads never overlap: the block runs one command at a time
  always_ff @(posedge clk_i) begin
    if (alloc_we) begin
      alloc_mem[in_tidx] <= in_tval;
    end
    if (alloc_re) begin
      alloc_rdata_q <= alloc_mem[alloc_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (chain_we) begin
      chain_mem[chain_waddr] <= next_q;
    end
    if (chain_re) begin
      chain_rdata_q <= chain_mem[chain_raddr];
    end
  end

  // offset/8 divided by 255: estimate with *257/65536, one correction step later
  logic [16:0] off_hi;
  logic [25:0] q_prod;
  logic [9:0]  q_est;

  assign off_hi = in_offset[19:3];
  assign q_prod = {9'b0, off_hi} + {1'b0, off_hi, 8'b0};
  assign q_est  = q_prod[25:16];

  logic [17:0] q_mul;
  logic [17:0] r_full;
  logic [8:0]  r_est;

  assign q_mul  = {idx_q, 8'b0} - {8'b0, idx_q};
  assign r_full = {1'b0, offset_q[19:3]} - q_mul;
  assign r_est  = r_full[8:0];

  // position within the block split into sector and byte
  logic [10:0] rem;
  logic [19:0] s_prod;
  logic [3:0]  s_est;
  logic [11:0] s_mul;
  logic [11:0] b_full;
  logic        s_fix;
  logic [3:0]  s_idx;
  logic [7:0]  b_val;

  assign rem    = {rmod_q, offset_q[2:0]};
  assign s_prod = {9'b0, rem} + {1'b0, rem, 8'b0};
  assign s_est  = s_prod[19:16];
  assign s_mul  = {s_est, 8'b0} - {8'b0, s_est};
  assign b_full = {1'b0, rem} - s_mul;
  assign s_fix  = (b_full >= {4'b0, fcs_pkg::SECTOR_BYTES});
  assign s_idx  = s_fix ? (s_est + 4'd1) : s_est;
  assign b_val  = s_fix ? 8'(b_full - {4'b0, fcs_pkg::SECTOR_BYTES}) : b_full[7:0];

  // open result
  logic        walk_go;
  logic        open_fail;
  logic [8:0]  steps_m1;
  logic [3:0]  lsc_m1;
  logic [19:0] blk_part;
  logic [11:0] sec_part;
  logic [19:0] new_size;

  assign walk_go   = (next_q <= fcs_pkg::LAST_BLOCK_CODE) && (steps_q < LEN_W'(MAX_CHAIN));
  assign open_fail = (steps_q == '0) || (next_q <= fcs_pkg::LAST_BLOCK_CODE) ||
                     (next_q < fcs_pkg::END_CODE_LOW) || (next_q > fcs_pkg::END_CODE_HIGH);
  assign steps_m1  = 9'(steps_q - LEN_W'(1));
  assign lsc_m1    = next_q[3:0] - 4'd1;
  assign blk_part  = {steps_m1, 11'b0} - {8'b0, steps_m1, 3'b0};
  assign sec_part  = {lsc_m1, 8'b0} - {8'b0, lsc_m1};
  assign new_size  = blk_part + {8'b0, sec_part} + {4'b0, lbytes_q};

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    lsc_d       = lsc_q;
    size_d      = size_q;
    steps_d     = steps_q;
    next_d      = next_q;
    lbytes_d    = lbytes_q;
    offset_d    = offset_q;
    idx_d       = idx_q;
    rmod_d      = rmod_q;
    bad_d       = bad_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    o_status_d  = o_status_q;
    o_block_d   = o_block_q;
    o_track_d   = o_track_q;
    o_sector_d  = o_sector_q;
    o_byte_d    = o_byte_q;
    o_size_d    = o_size_q;
    o_len_d     = o_len_q;
    alloc_we    = 1'b0;
    alloc_re    = 1'b0;
    alloc_raddr = next_q + 8'd1;
    chain_we    = 1'b0;
    chain_re    = 1'b0;
    chain_waddr = steps_q[CL_AW-1:0];
    chain_raddr = idx_q[CL_AW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          lbytes_d = in_lbytes;
          offset_d = in_offset;
          next_d   = in_first;
          steps_d  = '0;
          idx_d    = q_est;
          unique case (in_cmd)
            fcs_pkg::CMD_WRITE: begin
              alloc_we = 1'b1;
              state_d  = ST_PLAIN;
            end
            fcs_pkg::CMD_OPEN: state_d = ST_WALK;
            fcs_pkg::CMD_SEEK: state_d = ST_SK_IDX;
            default:           state_d = ST_PLAIN;
          endcase
        end
      end
      ST_PLAIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          o_status_d  = fcs_pkg::STAT_OK;
          o_block_d   = '0;
          o_track_d   = '0;
          o_sector_d  = '0;
          o_byte_d    = '0;
          o_size_d    = size_q;
          o_len_d     = count_q;
          state_d     = ST_IDLE;
        end
      end
      ST_WALK: begin
        if (walk_go) begin
          chain_we = 1'b1;
          alloc_re = 1'b1;
          steps_d  = steps_q + LEN_W'(1);
          state_d  = ST_WAIT;
        end else begin
          state_d = ST_OFIN;
        end
      end
      ST_WAIT: begin
        next_d  = alloc_rdata_q;
        state_d = ST_WALK;
      end
      ST_OFIN: begin
        if (out_free) begin
          if (open_fail) begin
            count_d    = '0;
            size_d     = '0;
            o_status_d = fcs_pkg::STAT_CHAIN;
            o_size_d   = '0;
          end else begin
            count_d    = steps_q;
            lsc_d      = next_q[3:0];
            size_d     = new_size;
            o_status_d = fcs_pkg::STAT_OK;
            o_size_d   = new_size;
          end
          out_valid_d = 1'b1;
          o_block_d   = '0;
          o_track_d   = '0;
          o_sector_d  = '0;
          o_byte_d    = '0;
          o_len_d     = steps_q;
          state_d     = ST_IDLE;
        end
      end
      ST_SK_IDX: begin
        if (r_est >= {1'b0, fcs_pkg::SECTOR_BYTES}) begin
          idx_d  = idx_q + 10'd1;
          rmod_d = 8'(r_est - {1'b0, fcs_pkg::SECTOR_BYTES});
        end else begin
          rmod_d = r_est[7:0];
        end
        state_d = ST_SK_CHK;
      end
      ST_SK_CHK: begin
        bad_d    = (offset_q > size_q) || (idx_q >= {1'b0, count_q});
        chain_re = (idx_q < {1'b0, count_q});
        state_d  = ST_SK_OUT;
      end
      ST_SK_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          o_size_d    = size_q;
          o_len_d     = count_q;
          if (bad_q) begin
            o_status_d = fcs_pkg::STAT_RANGE;
            o_block_d  = '0;
            o_track_d  = '0;
            o_sector_d = '0;
            o_byte_d   = '0;
          end else begin
            o_status_d = fcs_pkg::STAT_OK;
            o_block_d  = chain_rdata_q;
            o_track_d  = chain_rdata_q[7:1];
            o_sector_d = {1'b0, s_idx} + 5'd1 +
                         (chain_rdata_q[0] ? fcs_pkg::ODD_SECTOR_BASE : 5'd0);
            o_byte_d   = b_val;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      lsc_q       <= '0;
      size_q      <= '0;
      steps_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      lsc_q       <= lsc_d;
      size_q      <= size_d;
      steps_q     <= steps_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    next_q     <= next_d;
    lbytes_q   <= lbytes_d;
    offset_q   <= offset_d;
    idx_q      <= idx_d;
    rmod_q     <= rmod_d;
    bad_q      <= bad_d;
    o_status_q <= o_status_d;
    o_block_q  <= o_block_d;
    o_track_q  <= o_track_d;
    o_sector_q <= o_sector_d;
    o_byte_q   <= o_byte_d;
    o_size_q   <= o_size_d;
    o_len_q    <= o_len_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, o_len_q, o_size_q, o_byte_q, o_sector_q,
                            o_track_q, o_block_q, o_status_q};

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= LEN_W'(MAX_CHAIN))
    else $error("chain count above the chain limit");

  a_steps_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    steps_q <= LEN_W'(MAX_CHAIN))
    else $error("walk step counter above the chain limit");

  a_open_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OFIN && out_free && !open_fail) |=>
      (count_q == $past(steps_q) && size_q == o_size_q && m_axis_tvalid_o))
    else $error("open result and file registers disagree");

  a_seek_sector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SK_OUT && out_free && !bad_q) |=>
      (o_sector_q != 5'd0 && o_byte_q != 8'd255 && o_track_q == o_block_q[7:1]))
    else $error("seek produced a sector or byte out of range");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK || state_q == ST_WAIT) |-> !in_xfer)
    else $error("transfer accepted during a chain walk");

  // last sector count is zero after reset, else taken from an end code
  a_lsc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lsc_q <= 4'd8)
    else $error("last sector count outside the end code range");

endmodule

@@ tb/sv/tb_fat_chain_seek.sv @@
`timescale 1ns / 100ps
// tb_fat_chain_seek: self-checking bench for the allocation-table chain walker
// drives table writes, opens and seeks, predicts every reply and compares it
// depends on fcs_pkg and fat_chain_seek
module tb_fat_chain_seek;

  localparam int          BLOCK_BYTES = 2040;
  localparam int          ITEM_TARGET = 850;
  localparam int          CALM_TAIL   = 150;
  localparam int          QUIET_LIMIT = 4 * (2 * fcs_pkg::MAX_CHAIN_DEF + 3) + 100;
  localparam logic [1:0]  CMD_SPARE   = 2'd3;

  // command, table_index, table_value, first_block, last_bytes, file_offset from bit 0 up
  typedef struct packed {
    bit [1:0]  pad;
    bit [19:0] file_offset;
    bit [15:0] last_bytes;
    bit [7:0]  first_block;
    bit [7:0]  table_value;
    bit [7:0]  table_index;
    bit [1:0]  command;
  } fat_cmd_t;

  // status, block_number, track_number, sector_number, byte_in_sector,
  // size_of_file, chain_length from bit 0 up
  typedef struct packed {
    bit [4:0]  pad;
    bit [8:0]  chain_length;
    bit [19:0] size_of_file;
    bit [7:0]  byte_in_sector;
    bit [4:0]  sector_number;
    bit [6:0]  track_number;
    bit [7:0]  block_number;
    bit [1:0]  status;
  } seek_reply_t;

  class chain_seek_board_t;
    bit [7:0]    fat [256];
    bit          fat_written [256];
    bit [7:0]    chain_blocks [256];
    bit [8:0]    chain_len;
    bit [3:0]    last_sectors;
    bit [19:0]   file_size;
    seek_reply_t awaited_replies [$];
    int errors, n_write, n_open, n_bad_chain, n_seek, n_beyond, n_spare, longest_open;

    // table entry that an open from this block would read before it is ever written
    function int unwritten_link(bit [7:0] first);
      int blk;
      int steps;
      blk = first;
      steps = 0;
      while (blk <= fcs_pkg::LAST_BLOCK_CODE && steps < fcs_pkg::MAX_CHAIN_DEF) begin
        if (!fat_written[blk + 1]) return blk + 1;
        blk = fat[blk + 1];
        steps++;
      end
      return -1;
    endfunction

    function bit [1:0] walk_chain(bit [7:0] first, bit [15:0] used, output bit [8:0] steps);
      int blk;
      int n;
      int unsigned size;
      blk = first;
      n = 0;
      while (blk <= fcs_pkg::LAST_BLOCK_CODE && n < fcs_pkg::MAX_CHAIN_DEF) begin
        chain_blocks[n] = 8'(blk);
        blk = fat[blk + 1];
        n++;
      end
      steps = 9'(n);
      if (n > longest_open) longest_open = n;
      if (n == 0 || blk <= fcs_pkg::LAST_BLOCK_CODE || blk < fcs_pkg::END_CODE_LOW ||
          blk > fcs_pkg::END_CODE_HIGH) begin
        chain_len = '0;
        file_size = '0;
        return fcs_pkg::STAT_CHAIN;
      end
      last_sectors = blk[3:0];
      chain_len = 9'(n);
      size = (n - 1) * BLOCK_BYTES +
             (int'(last_sectors) - 1) * int'(fcs_pkg::SECTOR_BYTES) + int'(used);
      file_size = size[19:0];
      return fcs_pkg::STAT_OK;
    endfunction

    function void log_command(fat_cmd_t c);
      seek_reply_t reply;
      bit [8:0]    steps;
      bit [7:0]    blk;
      int unsigned off, idx, rem;
      reply = '0;
      reply.chain_length = chain_len;
      case (c.command)
        fcs_pkg::CMD_WRITE: begin
          fat[c.table_index] = c.table_value;
          fat_written[c.table_index] = 1'b1;
          n_write++;
        end
        fcs_pkg::CMD_OPEN: begin
          reply.status = walk_chain(c.first_block, c.last_bytes, steps);
          reply.chain_length = steps;
          n_open++;
          if (reply.status != fcs_pkg::STAT_OK) n_bad_chain++;
        end
        fcs_pkg::CMD_SEEK: begin
          off = c.file_offset;
          idx = off / BLOCK_BYTES;
          n_seek++;
          if (off > file_size || idx >= chain_len || idx > 255) begin
            reply.status = fcs_pkg::STAT_RANGE;
            n_beyond++;
          end else begin
            blk = chain_blocks[idx];
            rem = off % BLOCK_BYTES;
            reply.block_number   = blk;
            reply.track_number   = blk[7:1];
            reply.sector_number  = 5'(rem / fcs_pkg::SECTOR_BYTES + 1) +
                                   (blk[0] ? fcs_pkg::ODD_SECTOR_BASE : 5'd0);
            reply.byte_in_sector = 8'(off % fcs_pkg::SECTOR_BYTES);
          end
        end
        default: n_spare++;
      endcase
      reply.size_of_file = file_size;
      awaited_replies.push_back(reply);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned seen);
      if (want != seen) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, seen);
      end
    endfunction

    function void check_reply(logic [63:0] data);
      seek_reply_t want, got;
      got = seek_reply_t'(data);
      if (awaited_replies.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending, expected none, actual 0x%h", $time, data);
        return;
      end
      want = awaited_replies.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("block_number", want.block_number, got.block_number);
      compare_field("track_number", want.track_number, got.track_number);
      compare_field("sector_number", want.sector_number, got.sector_number);
      compare_field("byte_in_sector", want.byte_in_sector, got.byte_in_sector);
      compare_field("size_of_file", want.size_of_file, got.size_of_file);
      compare_field("chain_length", want.chain_length, got.chain_length);
      compare_field("upper padding", want.pad, got.pad);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [63:0] s_tdata = '0;
  logic        m_tready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [63:0] m_axis_tdata_o;

  chain_seek_board_t board;
  bit tx_idle_on, rx_idle_on;
  int items_sent, stall_left, quiet_cycles;

  fat_chain_seek dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // result side: check each transfer, then pick the next ready level
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_tready) board.check_reply(m_axis_tdata_o);
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 5) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("tb_fat_chain_seek NOT OK");
        $finish;
      end
    end
  end

  function automatic fat_cmd_t scrambled_cmd();
    fat_cmd_t c;
    c = {$urandom, $urandom};
    c.pad = '0;
    return c;
  endfunction

  task automatic send_cmd(input fat_cmd_t c);
    int gap;
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.log_command(c);
    items_sent++;
  endtask

  task automatic write_entry(input bit [7:0] idx, input bit [7:0] value);
    fat_cmd_t c;
    c = scrambled_cmd();
    c.command     = fcs_pkg::CMD_WRITE;
    c.table_index = idx;
    c.table_value = value;
    send_cmd(c);
  endtask

  // fill any link the walk would reach unwritten before issuing the open
  task automatic open_file(input bit [7:0] first, input bit [15:0] used);
    fat_cmd_t c;
    int hole;
    hole = board.unwritten_link(first);
    while (hole >= 0) begin
      write_entry(8'(hole), 8'($urandom_range(0, 255)));
      hole = board.unwritten_link(first);
    end
    c = scrambled_cmd();
    c.command     = fcs_pkg::CMD_OPEN;
    c.first_block = first;
    c.last_bytes  = used;
    send_cmd(c);
  endtask

  task automatic seek_to(input bit [19:0] off);
    fat_cmd_t c;
    c = scrambled_cmd();
    c.command     = fcs_pkg::CMD_SEEK;
    c.file_offset = off;
    send_cmd(c);
  endtask

  task automatic wait_replies_done();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (board.awaited_replies.size() != 0);
  endtask

  // one file: link a chain of distinct blocks, open it, seek around in it
  task automatic file_round();
    bit [7:0]  blocks [$];
    bit        taken [192];
    int        len, b, seeks;
    bit [7:0]  tail;
    bit [15:0] used;
    bit [19:0] off;
    case ($urandom_range(0, 29))
      0:                   len = $urandom_range(41, 190);
      1, 2, 3, 4, 5, 6:    len = $urandom_range(9, 40);
      default:             len = $urandom_range(1, 8);
    endcase
    while (blocks.size() < len) begin
      b = $urandom_range(0, fcs_pkg::LAST_BLOCK_CODE);
      if (!taken[b]) begin
        taken[b] = 1'b1;
        blocks.push_back(8'(b));
      end
    end
    for (int i = 0; i + 1 < len; i++) write_entry(8'(blocks[i] + 1), blocks[i + 1]);
    if ($urandom_range(0, 9) == 0)
      tail = $urandom_range(0, 1) ? fcs_pkg::END_CODE_LOW - 8'd1 :
             8'($urandom_range(fcs_pkg::END_CODE_HIGH + 1, 255));
    else
      tail = 8'($urandom_range(fcs_pkg::END_CODE_LOW, fcs_pkg::END_CODE_HIGH));
    write_entry(8'(blocks[len - 1] + 1), tail);
    used = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 16'hffff)) :
           16'($urandom_range(0, 255));
    open_file(blocks[0], used);
    seeks = $urandom_range(2, 8);
    repeat (seeks) begin
      case ($urandom_range(0, 5))
        0, 1, 2: off = 20'($urandom_range(0, board.file_size));
        3:       off = 20'($urandom_range(0, board.chain_len) * BLOCK_BYTES);
        4:       off = 20'(board.file_size + $urandom_range(0, 3));
        default: off = 20'($urandom_range(0, 20'hfffff));
      endcase
      seek_to(off);
    end
  endtask

  task automatic noise_burst();
    fat_cmd_t c;
    int n;
    n = $urandom_range(1, 4);
    repeat (n) begin
      case ($urandom_range(0, 7))
        0, 1, 2: write_entry(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        3, 4:    open_file(8'($urandom_range(0, 255)), 16'($urandom_range(0, 16'hffff)));
        5, 6:    seek_to(20'($urandom_range(0, 20'hfffff)));
        default: begin
          c = scrambled_cmd();
          c.command = CMD_SPARE;
          send_cmd(c);
        end
      endcase
    end
  endtask

  initial begin
    fat_cmd_t spare;
    bit calm;
    board = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // three-block chain 00 -> 05 -> 0a closed with eight sectors
    write_entry(8'h01, 8'h05);
    write_entry(8'h06, 8'h0a);
    write_entry(8'h0b, fcs_pkg::END_CODE_HIGH);
    open_file(8'h00, 16'hffff);
    seek_to(20'd0);
    seek_to(20'd2294);
    seek_to(20'd6119);
    seek_to(20'd71400);
    seek_to(20'hfffff);
    open_file(8'h00, 16'd0);
    seek_to(20'd5865);
    // single odd block, zero-size file
    write_entry(8'hc0, fcs_pkg::END_CODE_LOW);
    open_file(fcs_pkg::LAST_BLOCK_CODE, 16'd0);
    seek_to(20'd0);
    seek_to(20'd1);
    // end code just below the valid range, then a seek on the failed open
    write_entry(8'hc0, fcs_pkg::END_CODE_LOW - 8'd1);
    open_file(fcs_pkg::LAST_BLOCK_CODE, 16'hffff);
    seek_to(20'd0);
    write_entry(8'hff, 8'hff);
    write_entry(8'h00, 8'h00);
    open_file(8'hc0, 16'd100);
    // self loop runs to the step limit
    write_entry(8'h31, 8'h30);
    open_file(8'h30, 16'd5);
    write_entry(8'h21, 8'hff);
    open_file(8'h20, 16'd7);
    spare = '1;
    spare.pad = '0;
    spare.command = CMD_SPARE;
    send_cmd(spare);
    wait_replies_done();

    while (items_sent < ITEM_TARGET) begin
      calm = items_sent > ITEM_TARGET - CALM_TAIL;
      tx_idle_on = !calm && $urandom_range(0, 3) != 0;
      rx_idle_on = !calm && $urandom_range(0, 3) != 0;
      file_round();
      if ($urandom_range(0, 2) == 0) noise_burst();
      if ($urandom_range(0, 9) == 0) wait_replies_done();
    end

    wait_replies_done();
    repeat (40) @(posedge clk_i);
    $display("covered %0d table writes, %0d opens (%0d rejected, longest walk %0d steps)",
             board.n_write, board.n_open, board.n_bad_chain, board.longest_open);
    $display("and %0d seeks (%0d past the end), %0d unused commands, %0d mismatches",
             board.n_seek, board.n_beyond, board.n_spare, board.errors);
    if (board.errors == 0 && board.awaited_replies.size() == 0) begin
      $display("tb_fat_chain_seek OK");
    end else begin
      $display("tb_fat_chain_seek NOT OK");
    end
    $finish;
  end

endmodule
